FILE: design/sfdl_pkg.sv
`default_nettype none

package sfdl_pkg;

  localparam int DELAY_DEPTH = 131072;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int DLY_W       = 17;
  localparam int FB_W        = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int ACC_W       = SAMPLE_W + GAIN_W + 2;
  localparam int Q_FRAC      = 15;
  localparam int UNITY       = 32768;
  localparam int W_NEW       = 22938;
  localparam int W_OLD       = 9830;

  localparam logic [DLY_W-1:0]  DELAY_RST = DLY_W'(19200);
  localparam logic [FB_W-1:0]   FB_RST    = FB_W'(11469);
  localparam logic [GAIN_W-1:0] MIX_RST   = GAIN_W'(16384);

  localparam logic signed [ACC_W-1:0] SMAX       = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN       = ~SMAX;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (Q_FRAC - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_FEEDBACK = 2'd1,
    CFG_MIX      = 2'd2
  } sfdl_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LP,
    ST_WET,
    ST_FB
  } sfdl_state_e;

  typedef struct packed {
    logic              start;
    logic              do_lp;
    logic              do_wet;
    logic              do_fb;
    logic              echo_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
  } sfdl_ctrl_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [SAMPLE_W-1:0] r;
    if (v > SMAX) begin
      r = SAMPLE_W'(SMAX);
    end else if (v < SMIN) begin
      r = SAMPLE_W'(SMIN);
    end else begin
      r = SAMPLE_W'(v);
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] round_q15(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] t;
    t = v + ROUND_HALF;
    return t >>> Q_FRAC;
  endfunction

endpackage

`default_nettype wire

FILE: design/sfdl_lane.sv
`default_nettype none

module sfdl_lane (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  sfdl_pkg::sfdl_ctrl_t                    ctrl_i,
  input  logic signed [sfdl_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic        [sfdl_pkg::GAIN_W-1:0]      mix_i,
  input  logic        [sfdl_pkg::GAIN_W-1:0]      fb_i,
  output logic signed [sfdl_pkg::SAMPLE_W-1:0]    sample_o
);
  import sfdl_pkg::*;

  localparam logic signed [ACC_W-1:0] W_NEW_A = ACC_W'(W_NEW);
  localparam logic signed [ACC_W-1:0] W_OLD_A = ACC_W'(W_OLD);

  logic signed [SAMPLE_W-1:0] mem_q [DELAY_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic signed [SAMPLE_W-1:0] in_q;
  logic signed [SAMPLE_W-1:0] sm_q, sm_d;
  logic signed [SAMPLE_W-1:0] wr_data;
  logic signed [SAMPLE_W-1:0] echo;
  logic signed [ACC_W-1:0]    pdry_q, pdry_d;
  logic signed [ACC_W-1:0]    lp_acc, wet_acc, fb_acc;
  logic        [GAIN_W-1:0]   dry_gain;

  assign dry_gain = GAIN_W'(UNITY) - mix_i;
  assign echo     = ctrl_i.echo_ok ? rdata_q : '0;

  always_comb begin
    pdry_d   = ACC_W'(sample_i) * ACC_W'(signed'({1'b0, dry_gain}));
    lp_acc   = ACC_W'(echo) * W_NEW_A + ACC_W'(sm_q) * W_OLD_A;
    sm_d     = sat_sample(round_q15(lp_acc));
    wet_acc  = pdry_q + ACC_W'(sm_q) * ACC_W'(signed'({1'b0, mix_i}));
    sample_o = sat_sample(round_q15(wet_acc));
    fb_acc   = round_q15(ACC_W'(sm_q) * ACC_W'(signed'({1'b0, fb_i})));
    wr_data  = sat_sample(ACC_W'(in_q) + fb_acc);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rdata_q <= mem_q[ctrl_i.rd_addr];
      in_q    <= sample_i;
      pdry_q  <= pdry_d;
    end
    if (ctrl_i.do_fb) begin
      mem_q[ctrl_i.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q <= '0;
    end else if (ctrl_i.do_lp) begin
      sm_q <= sm_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/sfdl_merge.sv
`default_nettype none

module sfdl_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic signed [sfdl_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [sfdl_pkg::SAMPLE_W-1:0] right_i,
  input  logic                                 stall_i,
  output logic                                 valid_o,
  output logic signed [sfdl_pkg::SAMPLE_W-1:0] left_o,
  output logic signed [sfdl_pkg::SAMPLE_W-1:0] right_o,
  output logic                                 space_o
);
  import sfdl_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [SAMPLE_W-1:0] left_q, right_q;

  assign space_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign left_o  = left_q;
  assign right_o = right_q;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q  <= left_i;
      right_q <= right_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/stereo_feedback_delay_lowpass_top.sv
`default_nettype none

// Stereo feedback echo with a one-pole lowpass in each echo path. One stereo
// pair is taken per request and yields one output pair. Each pair passes
// through memory read at acceptance, lowpass update, wet/dry mix into the
// output register, and feedback write before the next pair is accepted, one
// step per cycle through the single port of each channel's delay memory. The
// mix step waits while the output register still holds an untaken result.
// There is no clearing pass after reset: the write pointer and a wrap flag
// mark which memory entries were written, and entries never written read as
// zero. Write configuration only while no pair is in flight.
module stereo_feedback_delay_lowpass_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [sfdl_pkg::SAMPLE_W-1:0]   left_in_i,
  input  logic signed [sfdl_pkg::SAMPLE_W-1:0]   right_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [sfdl_pkg::SAMPLE_W-1:0]   left_out_o,
  output logic signed [sfdl_pkg::SAMPLE_W-1:0]   right_out_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [sfdl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [sfdl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sfdl_pkg::*;

  localparam int CMP_W = (DLY_W > ADDR_W) ? DLY_W : ADDR_W;
  localparam int AW1   = ADDR_W + 1;

  sfdl_state_e state_q, state_d;

  logic [DLY_W-1:0]  delay_q;
  logic [FB_W-1:0]   fb_q;
  logic [GAIN_W-1:0] mix_q;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic              wrapped_q, wrapped_d;
  logic              echo_ok_q;

  logic [CMP_W-1:0]  d_ext;
  logic [ADDR_W-1:0] dc;
  logic [AW1-1:0]    rd_sum;
  logic [ADDR_W-1:0] rd_addr;
  logic              echo_ok_d;
  logic [GAIN_W-1:0] mix_c;
  logic [GAIN_W-1:0] fb_ext;

  logic              accept;
  logic              out_space;
  sfdl_ctrl_t        ctrl;

  logic signed [SAMPLE_W-1:0] left_mix, right_mix;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    d_ext = CMP_W'(delay_q);
    if (d_ext == '0) begin
      dc = ADDR_W'(1);
    end else if (d_ext > CMP_W'(DELAY_DEPTH - 1)) begin
      dc = ADDR_W'(DELAY_DEPTH - 1);
    end else begin
      dc = ADDR_W'(d_ext);
    end
    rd_sum = AW1'(DELAY_DEPTH) + {1'b0, wp_q} - {1'b0, dc};
    if (wp_q >= dc) begin
      rd_addr = wp_q - dc;
    end else begin
      rd_addr = rd_sum[ADDR_W-1:0];
    end
    echo_ok_d = wrapped_q || (rd_addr < wp_q);
    mix_c     = (mix_q > GAIN_W'(UNITY)) ? GAIN_W'(UNITY) : mix_q;
    fb_ext    = GAIN_W'(fb_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LP;
      ST_LP:   state_d = ST_WET;
      ST_WET:  if (out_space) state_d = ST_FB;
      ST_FB:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    ctrl.start   = accept;
    ctrl.do_lp   = (state_q == ST_LP);
    ctrl.do_wet  = (state_q == ST_WET) && out_space;
    ctrl.do_fb   = (state_q == ST_FB);
    ctrl.echo_ok = echo_ok_q;
    ctrl.rd_addr = rd_addr;
    ctrl.wr_addr = wp_q;
  end

  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (ctrl.do_fb) begin
      if (wp_q == ADDR_W'(DELAY_DEPTH - 1)) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      echo_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      if (accept) begin
        echo_ok_q <= echo_ok_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RST;
      fb_q    <= FB_RST;
      mix_q   <= MIX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sfdl_cfg_e'(cfg_index_i))
        CFG_DELAY:    delay_q <= cfg_data_i[DLY_W-1:0];
        CFG_FEEDBACK: fb_q    <= cfg_data_i[FB_W-1:0];
        CFG_MIX:      mix_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  sfdl_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (left_in_i),
    .mix_i    (mix_c),
    .fb_i     (fb_ext),
    .sample_o (left_mix)
  );

  sfdl_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (right_in_i),
    .mix_i    (mix_c),
    .fb_i     (fb_ext),
    .sample_o (right_mix)
  );

  sfdl_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (ctrl.do_wet),
    .left_i  (left_mix),
    .right_i (right_mix),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .left_o  (left_out_o),
    .right_o (right_out_o),
    .space_o (out_space)
  );

endmodule

`default_nettype wire

FILE: design/sfdl_checker.sv
`default_nettype none

module sfdl_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic signed [sfdl_pkg::SAMPLE_W-1:0]   left_in_i,
  input logic signed [sfdl_pkg::SAMPLE_W-1:0]   right_in_i,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [sfdl_pkg::SAMPLE_W-1:0]   left_out_o,
  input logic signed [sfdl_pkg::SAMPLE_W-1:0]   right_out_o,
  input logic                                   cfg_valid_i,
  input logic                                   cfg_ready_o,
  input logic        [sfdl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic        [sfdl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sfdl_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{left_in_i, right_in_i, cfg_valid_i, cfg_ready_o,
                       cfg_index_i, cfg_data_i};

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after request");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no request in work");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(left_out_o) && $stable(right_out_o)))
    else $error("stalled result changed");

endmodule

bind stereo_feedback_delay_lowpass_top sfdl_checker u_sfdl_checker (.*);

`default_nettype wire

FILE: bench/stereo_feedback_delay_lowpass_top_tb.sv
module stereo_feedback_delay_lowpass_top_tb;
  import sfdl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_pair_t;

  class echo_scoreboard;
    bit signed [SAMPLE_W-1:0] mem [2][DELAY_DEPTH];
    bit signed [SAMPLE_W-1:0] smoothed [2];
    bit [ADDR_W-1:0] wr_ptr;
    bit [DLY_W-1:0] delay_reg;
    bit [FB_W-1:0] fb_reg;
    bit [GAIN_W-1:0] mix_reg;
    stereo_pair_t expected_q[$];
    int failures;

    function new();
      delay_reg = DELAY_RST;
      fb_reg = FB_RST;
      mix_reg = MIX_RST;
      wr_ptr = '0;
      failures = 0;
    endfunction

    function void update_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DELAY: delay_reg = data[DLY_W-1:0];
        CFG_FEEDBACK: fb_reg = data[FB_W-1:0];
        CFG_MIX: mix_reg = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint round_q(longint v);
      return (v + 64'sd16384) >>> Q_FRAC;
    endfunction

    function longint clip(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function logic signed [SAMPLE_W-1:0] step_channel(int ch, longint din,
                                                      bit [ADDR_W-1:0] rd, longint mix);
      longint echo;
      longint old;
      longint s;
      longint fb;
      longint dout;
      longint wr;
      echo = mem[ch][rd];
      old = smoothed[ch];
      fb = fb_reg;
      s = clip(round_q(echo * W_NEW + old * W_OLD));
      smoothed[ch] = SAMPLE_W'(s);
      dout = clip(round_q(din * (UNITY - mix) + s * mix));
      wr = clip(din + round_q(s * fb));
      mem[ch][wr_ptr] = SAMPLE_W'(wr);
      return SAMPLE_W'(dout);
    endfunction

    function void note(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      bit [DLY_W-1:0] d;
      longint mix;
      bit [ADDR_W-1:0] rd;
      stereo_pair_t p;
      d = delay_reg;
      if (d == 0) d = DLY_W'(1);
      if (d > DELAY_DEPTH - 1) d = DLY_W'(DELAY_DEPTH - 1);
      mix = mix_reg;
      if (mix > UNITY) mix = UNITY;
      rd = wr_ptr - ADDR_W'(d);
      p.left = step_channel(0, l, rd, mix);
      p.right = step_channel(1, r, rd, mix);
      wr_ptr = wr_ptr + 1'b1;
      expected_q.push_back(p);
    endfunction

    function void check(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      stereo_pair_t p;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected output pair: left %0d right %0d", l, r);
        return;
      end
      p = expected_q.pop_front();
      if (p.left !== l || p.right !== r) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
                   p.left, l, p.right, r);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SAMPLE_W-1:0] left_in_i = '0;
  logic signed [SAMPLE_W-1:0] right_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out_o;
  logic signed [SAMPLE_W-1:0] right_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  echo_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_seg = 0;

  stereo_feedback_delay_lowpass_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(negedge clk_i) begin
    if (stall_seg == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_seg = $urandom_range(10, 80);
    end
    stall_seg--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'($urandom_range(0, 1));
      2: out_stall_i <= ($urandom_range(0, 7) == 0);
      default: out_stall_i <= ((stall_seg % 8) < 5);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check(left_out_o, right_out_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r);
    in_valid_i <= 1'b1;
    left_in_i <= l;
    right_in_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note(l, r);
    @(negedge clk_i);
  endtask

  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.update_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] d, input logic [CFG_DATA_W-1:0] fb,
                           input logic [CFG_DATA_W-1:0] mix);
    load_reg(CFG_DELAY, d);
    load_reg(CFG_FEEDBACK, fb);
    load_reg(CFG_MIX, mix);
  endtask

  // hold off until every request has its output pair and the feedback write is done
  task automatic drain_echo();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return SAMPLE_W'($urandom);
    if (sel < 60) return SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
    if (sel < 68) return 16'sh7fff;
    if (sel < 76) return 16'sh8000;
    if (sel < 90) return '0;
    return $urandom_range(0, 1) ? 16'sh4000 : 16'shc000;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return CFG_DATA_W'($urandom_range(1, 48));
    if (sel == 6) return '0;
    if (sel == 7) return CFG_DATA_W'(DELAY_DEPTH - 1);
    if (sel == 8) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(49, 2000));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_feedback();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 6) return CFG_DATA_W'($urandom_range(0, 31130));
    if (sel < 10) return CFG_DATA_W'(31130);
    if (sel < 13) return '0;
    if (sel < 16) return CFG_DATA_W'($urandom_range(31131, 32767));
    return CFG_DATA_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_mix();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 6) return CFG_DATA_W'($urandom_range(0, UNITY));
    if (sel < 9) return '0;
    if (sel < 12) return CFG_DATA_W'(UNITY);
    if (sel < 16) return CFG_DATA_W'($urandom_range(UNITY + 1, 65535));
    return CFG_DATA_W'($urandom);
  endfunction

  task automatic send_stream(input int n);
    int burst;
    int gap;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < n; i++) begin
      send_pair(pick_sample(), pick_sample());
      burst--;
      if (burst == 0) begin
        gap = $urandom_range(0, 12);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  initial begin
    int total;
    int n;
    total = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh0000, 16'sh0000);
    drain_echo();

    // zero delay, oversized feedback and mix, write to an unused index
    configure('0, 17'h1ffff, 17'h0ffff);
    load_reg(CFG_UNUSED, 17'h1ffff);
    repeat (4) send_pair(16'sh7fff, 16'sh7fff);
    repeat (3) send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh0001, 16'shffff);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh0000, 16'sh0000);
    drain_echo();

    configure(CFG_DATA_W'(DELAY_DEPTH - 1), '0, '0);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh5555, 16'shaaaa);
    send_pair(16'shaaaa, 16'sh5555);
    send_pair(16'sh0000, 16'shffff);
    drain_echo();

    configure(CFG_DATA_W'(2), CFG_DATA_W'(31130), CFG_DATA_W'(UNITY));
    repeat (3) send_pair(16'sh7fff, 16'sh8000);
    repeat (3) send_pair(16'sh8000, 16'sh7fff);
    drain_echo();

    while (total < RANDOM_ITEMS) begin
      n = $urandom_range(60, 180);
      configure(pick_delay(), pick_feedback(), pick_mix());
      if ($urandom_range(0, 3) == 0) load_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      send_stream(n);
      drain_echo();
      total += n;
    end

    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
